// ----- rtl/sha1md_pkg.sv -----
`timescale 1ns / 1ps

package sha1md_pkg;

    typedef logic [31:0] word_t;

    // element 0 is the first word (a / h0)
    typedef logic [4:0][31:0]  hash_t;
    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } digest_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_BUSY,
        S_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    // h4 down to h0
    localparam hash_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                32'hefcdab89, 32'h67452301};

    localparam word_t K_0 = 32'h5a827999;
    localparam word_t K_1 = 32'h6ed9eba1;
    localparam word_t K_2 = 32'h8f1bbcdc;
    localparam word_t K_3 = 32'hca62c1d6;

    localparam logic [6:0] ROUND_20   = 7'd20;
    localparam logic [6:0] ROUND_40   = 7'd40;
    localparam logic [6:0] ROUND_60   = 7'd60;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [2:0] FULL_WORD  = 3'd4;
    localparam logic [3:0] LAST_WORD  = 4'd15;
    localparam logic [3:0] LEN_WORD   = 4'd14;
    localparam word_t      PAD_WORD   = 32'h8000_0000;

endpackage

// ----- rtl/sha1md_core.sv -----
`timescale 1ns / 1ps

module sha1md_core import sha1md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  blk_t       blk,
    input  hash_t      h_in,
    output core_stat_t stat,
    output hash_t      h_out
);

    core_state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    blk_t  w_reg;

    word_t f_val;
    word_t k_val;
    word_t t_val;
    word_t w_new;
    word_t w_mix;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.busy  = (state_reg != C_IDLE);
        stat.done  = (state_reg == C_ADD);
        round_next = (state_reg == C_ROUND) ? 7'(round_reg + 7'd1) : 7'd0;
    end

    // one round of the shared round unit
    always_comb
    begin
        if (round_reg < ROUND_20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < ROUND_40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < ROUND_60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
        // schedule word t+16 from the 16-word window
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
    end

    always_comb
    begin
        h_out[0] = h_in[0] + a_reg;
        h_out[1] = h_in[1] + b_reg;
        h_out[2] = h_in[2] + c_reg;
        h_out[3] = h_in[3] + d_reg;
        h_out[4] = h_in[4] + e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            a_reg <= h_in[0];
            b_reg <= h_in[1];
            c_reg <= h_in[2];
            d_reg <= h_in[3];
            e_reg <= h_in[4];
            w_reg <= blk;
        end
        else if (state_reg == C_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            w_reg <= {w_new, w_reg[15:1]};
        end
    end

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ROUND && round_reg == LAST_ROUND) |=> state_reg == C_ADD)
        else $error("round loop did not end after the last round");

    a_add_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_ADD |=> state_reg == C_IDLE)
        else $error("final add held for more than one cycle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == C_IDLE)
        else $error("start while a compression is running");

    a_round_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_IDLE |-> round_reg == 7'd0)
        else $error("round counter not cleared while idle");

endmodule

// ----- rtl/sha1_message_digest_unit.sv -----
`timescale 1ns / 1ps

// SHA-1 digest unit. Message words (big-endian, first byte in bits 31:24) arrive on the msg
// channel with a valid-byte count and a last flag; a count below four or the last flag ends the
// message. A word that does not complete a 64-byte block is stored in the block buffer. A word
// that completes a block starts a compression (load, 80 rounds through one shared round unit,
// chaining add), during which msg_ready stays low. Ending a message takes padding (S_PAD after a
// full last word, then S_LEN) plus one compression, or two when the pad and length do not fit
// the current block. The digest is held in an output register, so the next message can start
// while it waits to be taken. Throughput is set by the round unit: no new word is taken while a
// compression runs.

module sha1_message_digest_unit import sha1md_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    msg_valid,
    output logic    msg_ready,
    input  msg_t    msg,
    output logic    digest_valid,
    input  logic    digest_ready,
    output digest_t digest
);

    top_state_t state_reg, state_next;
    top_state_t ret_reg, ret_next;
    blk_t       blk_reg, blk_next;
    logic [3:0] wcnt_reg, wcnt_next;
    logic [63:0] len_reg, len_next;
    hash_t      h_reg, h_next;
    digest_t    out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       msg_fire;
    logic       out_free;
    logic [2:0] bc;
    logic       full;
    word_t      mask;
    word_t      pad;
    word_t      data_word;
    logic       core_start;
    logic       load_len;
    blk_t       core_blk;
    core_stat_t core_stat;
    hash_t      core_h;

    assign msg_fire = msg_valid && msg_ready;
    assign out_free = !out_valid_reg || digest_ready;

    // counts above four act as four
    always_comb
    begin
        bc   = (msg.byte_count > FULL_WORD) ? FULL_WORD : msg.byte_count;
        full = (bc == FULL_WORD);
        case (bc)
            3'd0:    begin mask = 32'h0000_0000; pad = 32'h8000_0000; end
            3'd1:    begin mask = 32'hff00_0000; pad = 32'h0080_0000; end
            3'd2:    begin mask = 32'hffff_0000; pad = 32'h0000_8000; end
            3'd3:    begin mask = 32'hffff_ff00; pad = 32'h0000_0080; end
            default: begin mask = 32'hffff_ffff; pad = 32'h0000_0000; end
        endcase
        data_word = (msg.message_word & mask) | pad;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_fire)
                begin
                    if (!full)
                    begin
                        state_next = S_LEN;
                    end
                    else if (wcnt_reg == LAST_WORD)
                    begin
                        state_next = S_BUSY;
                    end
                    else if (msg.last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                state_next = S_LEN;
            end
            S_LEN:
            begin
                state_next = S_BUSY;
            end
            S_BUSY:
            begin
                if (core_stat.done)
                begin
                    state_next = ret_reg;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        msg_ready      = (state_reg == S_IDLE);
        ret_next       = ret_reg;
        blk_next       = blk_reg;
        wcnt_next      = wcnt_reg;
        len_next       = len_reg;
        h_next         = h_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !digest_ready;
        core_start     = 1'b0;
        load_len       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_fire)
                begin
                    blk_next[wcnt_reg] = data_word;
                    len_next = len_reg + {58'd0, bc, 3'd0};
                    if (full)
                    begin
                        wcnt_next = 4'(wcnt_reg + 4'd1);
                        if (wcnt_reg == LAST_WORD)
                        begin
                            core_start = 1'b1;
                            ret_next   = msg.last ? S_PAD : S_IDLE;
                        end
                    end
                end
            end
            S_PAD:
            begin
                blk_next[wcnt_reg] = PAD_WORD;
            end
            S_LEN:
            begin
                core_start = 1'b1;
                if (wcnt_reg >= LEN_WORD)
                begin
                    // no room for the length: compress, then a block of only the length
                    wcnt_next = 4'd0;
                    ret_next  = S_LEN;
                end
                else
                begin
                    load_len = 1'b1;
                    ret_next = S_OUT;
                end
            end
            S_BUSY:
            begin
                if (core_stat.done)
                begin
                    h_next = core_h;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
                    out_valid_next = 1'b1;
                    h_next         = H_INIT;
                    wcnt_next      = 4'd0;
                    len_next       = 64'd0;
                end
            end
            default:
            begin
            end
        endcase

        // the core copies the block at start, so the buffer empties at once
        if (core_start)
        begin
            blk_next = '0;
        end
    end

    always_comb
    begin
        core_blk = blk_reg;
        // the word that completes a block goes straight to the core
        if (msg_fire)
        begin
            core_blk[wcnt_reg] = data_word;
        end
        if (load_len)
        begin
            core_blk[14] = len_reg[63:32];
            core_blk[15] = len_reg[31:0];
        end
    end

    sha1md_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .blk   (core_blk),
        .h_in  (h_reg),
        .stat  (core_stat),
        .h_out (core_h)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            blk_reg       <= '0;
            wcnt_reg      <= 4'd0;
            len_reg       <= 64'd0;
            h_reg         <= H_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            blk_reg       <= blk_next;
            wcnt_reg      <= wcnt_next;
            len_reg       <= len_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg_ready |-> !core_stat.busy)
        else $error("request taken while a compression is running");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == S_BUSY)
        else $error("compression finished outside the wait state");

    a_digest_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (digest_valid && len_reg == 64'd0
            && wcnt_reg == 4'd0 && h_reg == H_INIT))
        else $error("digest issued without restarting the message state");

endmodule
